>>> hw/rtl/swld_pkg.sv
package swld_pkg;

   localparam logic [31:0] SYNC_RESET = 32'h4141_4141;
   localparam logic [2:0]  HDR_BYTES  = 3'd4;

   typedef struct packed {
      logic        has_result;
      logic [7:0]  payload_byte;
      logic        last_byte;
      logic        empty_message;
      logic [31:0] message_length;
   } swld_result_type;

endpackage

>>> hw/rtl/swld_req_if.sv
interface swld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

>>> hw/rtl/swld_rsp_if.sv
interface swld_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic        last_byte;
   logic        empty_message;
   logic [31:0] message_length;

   modport source (output valid, output payload_byte, output last_byte,
                   output empty_message, output message_length, input ready);
   modport sink   (input valid, input payload_byte, input last_byte,
                   input empty_message, input message_length, output ready);
endinterface

>>> hw/rtl/swld_csr_if.sv
interface swld_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] sync_word;

   modport source (output valid, output sync_word, input ready);
   modport sink   (input valid, input sync_word, output ready);
endinterface

>>> hw/rtl/swld_in_reg.sv
module swld_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_data,
   input  logic       advance,
   output logic       held_valid,
   output logic [7:0] held_data
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;

   // The held item leaves whenever the core consumes it, so a new item
   // can be taken in that same cycle.
   assign in_ready   = !valid_ff || advance;
   assign valid_in   = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_ff);
   assign held_valid = valid_ff;
   assign held_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

>>> hw/rtl/swld_core.sv
module swld_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                data_byte,
   input  logic [31:0]               sync_word,
   output swld_pkg::swld_result_type result
);

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN  = 2'd1,
      PH_PAY  = 2'd2
   } phase_type;

   phase_type   phase_ff,  phase_in;
   logic [31:0] window_ff, window_in;
   logic [2:0]  fill_ff,   fill_in;
   logic [31:0] len_ff,    len_in;
   logic [1:0]  lcnt_ff,   lcnt_in;
   logic [31:0] remain_ff, remain_in;

   logic [31:0] shifted_win;
   logic [2:0]  fill_sat;
   logic [31:0] shifted_len;
   logic [31:0] remain_dec;

   assign shifted_win = {window_ff[23:0], data_byte};
   assign fill_sat    = (fill_ff < swld_pkg::HDR_BYTES) ? fill_ff + 3'd1 : fill_ff;
   // Length arrives little-endian: each new byte enters at the top.
   assign shifted_len = {data_byte, len_ff[31:8]};
   assign remain_dec  = remain_ff - 32'd1;

   always_comb begin
      phase_in  = phase_ff;
      window_in = window_ff;
      fill_in   = fill_ff;
      len_in    = len_ff;
      lcnt_in   = lcnt_ff;
      remain_in = remain_ff;
      result    = '0;
      unique case (phase_ff)
         PH_LEN: begin
            len_in = shifted_len;
            if (lcnt_ff == 2'(swld_pkg::HDR_BYTES - 3'd1)) begin
               lcnt_in = 2'd0;
               if (shifted_len == 32'd0) begin
                  window_in            = '0;
                  fill_in              = '0;
                  phase_in             = PH_HUNT;
                  result.has_result    = 1'b1;
                  result.last_byte     = 1'b1;
                  result.empty_message = 1'b1;
               end else begin
                  remain_in = shifted_len;
                  phase_in  = PH_PAY;
               end
            end else begin
               lcnt_in = lcnt_ff + 2'd1;
            end
         end
         PH_PAY: begin
            remain_in             = remain_dec;
            result.has_result     = 1'b1;
            result.payload_byte   = data_byte;
            result.message_length = len_ff;
            if (remain_dec == 32'd0) begin
               result.last_byte = 1'b1;
               window_in        = '0;
               fill_in          = '0;
               phase_in         = PH_HUNT;
            end
         end
         default: begin
            phase_in  = PH_HUNT;
            window_in = shifted_win;
            fill_in   = fill_sat;
            if (fill_sat >= swld_pkg::HDR_BYTES && shifted_win == sync_word) begin
               phase_in = PH_LEN;
               len_in   = '0;
               lcnt_in  = '0;
            end
         end
      endcase
      if (!step) begin
         result.has_result = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         window_ff <= '0;
         fill_ff   <= '0;
         len_ff    <= '0;
         lcnt_ff   <= '0;
         remain_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         window_ff <= window_in;
         fill_ff   <= fill_in;
         len_ff    <= len_in;
         lcnt_ff   <= lcnt_in;
         remain_ff <= remain_in;
      end
   end

endmodule

>>> hw/rtl/swld_out_reg.sv
module swld_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  swld_pkg::swld_result_type result,
   output logic                      slot_free,
   swld_rsp_if.source                rsp_ch
);

   logic                      valid_ff;
   logic                      valid_in;
   swld_pkg::swld_result_type data_ff;

   assign slot_free = !valid_ff || rsp_ch.ready;
   assign valid_in  = result.has_result ? 1'b1 : (rsp_ch.ready ? 1'b0 : valid_ff);

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.payload_byte   = data_ff.payload_byte;
   assign rsp_ch.last_byte      = data_ff.last_byte;
   assign rsp_ch.empty_message  = data_ff.empty_message;
   assign rsp_ch.message_length = data_ff.message_length;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (result.has_result) begin
         data_ff <= result;
      end
   end

endmodule

>>> hw/rtl/sync_word_length_deframer.sv
// Channel   Direction  Payload
// req_ch    in         data_byte[7:0]
// rsp_ch    out        payload_byte[7:0], last_byte, empty_message, message_length[31:0]
// csr_ch    in         sync_word[31:0], always ready
//
// One item per cycle sustained while rsp_ch is ready: each item waits in the input
// register; its result, if any, enters the result register as the item advances.
// The input register advances whenever the result register is empty or being
// drained, so rsp_ch stalls back up into req_ch with no lost cycle.
// Synchronous active-high reset clears the hunt state and sets sync_word to "AAAA".
module sync_word_length_deframer (
   input  logic       clock,
   input  logic       reset,
   swld_req_if.sink   req_ch,
   swld_rsp_if.source rsp_ch,
   swld_csr_if.sink   csr_ch
);

   logic                      held_valid;
   logic [7:0]                held_data;
   logic                      slot_free;
   logic                      advance;
   logic [31:0]               sync_ff;
   swld_pkg::swld_result_type result;

   assign advance      = held_valid && slot_free;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= swld_pkg::SYNC_RESET;
      end else if (csr_ch.valid) begin
         sync_ff <= csr_ch.sync_word;
      end
   end

   swld_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_data    (req_ch.data_byte),
      .advance    (advance),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   swld_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (held_data),
      .sync_word (sync_ff),
      .result    (result)
   );

   swld_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .slot_free (slot_free),
      .rsp_ch    (rsp_ch)
   );

endmodule
